// ----- hw/rtl/rwh_pkg.sv -----
`default_nettype none

package rwh_pkg;

   localparam int SLOTS_DEFAULT = 256;
   localparam int TERMS_DEFAULT = 3;

   localparam int CMD_W     = 2;
   localparam int POS_W     = 11;
   localparam int STR_W     = 9;
   localparam int AGE_W     = 15;
   localparam int ELAPSED_W = 16;
   localparam int PHASE_W   = 16;
   localparam int HEIGHT_W  = 12;
   localparam int SWIDTH_W  = 11;
   localparam int LEVEL_W   = 12;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 12;
   localparam int ACC_W     = 42;
   localparam int FRAC_W    = 23;

   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_PX     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEVEL  = 1'd1;

   localparam logic [SWIDTH_W-1:0] SPAN_PX_RESET    = 11'd1024;
   localparam logic [LEVEL_W-1:0]  BASE_LEVEL_RESET = 12'd360;
   localparam logic [16:0]         LIFE_UNITS       = 17'd21846;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [AGE_W-1:0] age;
      logic [STR_W-1:0] strength;
   } slot_word_type;

   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] position;
      logic [AGE_W-1:0] age;
      logic [STR_W-1:0] strength;
   } slot_beat_type;

   localparam logic [14:0] SIN_QUARTER [0:64] = '{
      15'd0, 15'd804, 15'd1608, 15'd2410, 15'd3212, 15'd4011, 15'd4808, 15'd5602,
      15'd6393, 15'd7179, 15'd7962, 15'd8739, 15'd9512, 15'd10278, 15'd11039,
      15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151,
      15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787,
      15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279, 15'd24811,
      15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683, 15'd28105,
      15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273, 15'd30571,
      15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971, 15'd32137,
      15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
      15'd32767
   };

   localparam logic [14:0] EXP_WHOLE [0:15] = '{
      15'd32767, 15'd12054, 15'd4435, 15'd1631, 15'd600, 15'd221, 15'd81, 15'd30,
      15'd11, 15'd4, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0
   };

   localparam logic [14:0] EXP_PART [0:31] = '{
      15'd32767, 15'd31759, 15'd30782, 15'd29834, 15'd28917, 15'd28027, 15'd27165,
      15'd26329, 15'd25519, 15'd24734, 15'd23973, 15'd23235, 15'd22520, 15'd21828,
      15'd21156, 15'd20505, 15'd19874, 15'd19263, 15'd18670, 15'd18096, 15'd17539,
      15'd16999, 15'd16476, 15'd15969, 15'd15478, 15'd15002, 15'd14540, 15'd14093,
      15'd13659, 15'd13239, 15'd12832, 15'd12437
   };

   localparam logic [11:0] WAVE_AMP [0:7] = '{
      12'd1920, 12'd768, 12'd333, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
   };

   function automatic logic signed [15:0] sine_q15(input logic [15:0] angle);
      logic [15:0] r;
      logic [7:0]  idx;
      logic [5:0]  k;
      logic [14:0] mag;
      r   = angle + 16'd128;
      idx = r[15:8];
      k   = idx[5:0];
      if (idx[6]) begin
         mag = SIN_QUARTER[7'd64 - {1'b0, k}];
      end else begin
         mag = SIN_QUARTER[{1'b0, k}];
      end
      if (idx[7]) begin
         return -$signed({1'b0, mag});
      end
      return $signed({1'b0, mag});
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rwh_wave_unit.sv -----
`default_nettype none

module rwh_wave_unit import rwh_pkg::*; #(
   parameter int WAVE_TERMS = TERMS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [POS_W-1:0]        query_pos,
   input  wire logic [SWIDTH_W-1:0]     span_px,
   input  wire logic [PHASE_W-1:0]      phase,
   output logic                         busy,
   output logic signed [ACC_W-1:0]      acc
);

   localparam int TW   = $clog2(WAVE_TERMS + 1);
   localparam int NUMW = TW + POS_W + 16;
   localparam int SW   = $clog2(NUMW + 1);

   localparam logic [1:0] W_IDLE = 2'd0;
   localparam logic [1:0] W_DIV  = 2'd1;
   localparam logic [1:0] W_MUL  = 2'd2;
   localparam logic [1:0] W_ACC  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [TW-1:0]          k_ff, k_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [NUMW-1:0]        num_ff, num_in;
   logic [SWIDTH_W-1:0]    rem_ff, rem_in;
   logic [15:0]            quo_ff, quo_in;
   logic [POS_W-1:0]       qpos_ff, qpos_in;
   logic signed [28:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic [SWIDTH_W-1:0]    w_eff;
   logic [SWIDTH_W:0]      rem_sh;
   logic                   take;
   logic signed [15:0]     sn;
   logic [TW-1:0]          k_next;
   logic [TW+POS_W-1:0]    kx_next;

   assign w_eff  = (span_px == '0) ? SWIDTH_W'(1) : span_px;
   assign rem_sh = {rem_ff, num_ff[NUMW-1]};
   assign take   = rem_sh >= {1'b0, w_eff};
   assign sn     = sine_q15(quo_ff + phase);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      qpos_in  = qpos_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      k_next   = (state_ff == W_IDLE) ? TW'(1) : k_ff + TW'(1);
      kx_next  = (TW + POS_W)'(k_next) *
                 (TW + POS_W)'((state_ff == W_IDLE) ? query_pos : qpos_ff);
      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               state_in = W_DIV;
               acc_in   = '0;
               qpos_in  = query_pos;
            end
         end
         W_DIV: begin
            num_in  = {num_ff[NUMW-2:0], 1'b0};
            rem_in  = take ? SWIDTH_W'(rem_sh - {1'b0, w_eff}) : rem_sh[SWIDTH_W-1:0];
            quo_in  = {quo_ff[14:0], take};
            step_in = step_ff - SW'(1);
            if (step_ff == SW'(1)) begin
               state_in = W_MUL;
            end
         end
         W_MUL: begin
            prod_in  = $signed(29'(sn)) * $signed({17'b0, WAVE_AMP[3'(k_ff - TW'(1))]});
            state_in = W_ACC;
         end
         W_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            if (k_ff == TW'(WAVE_TERMS)) begin
               state_in = W_IDLE;
            end else begin
               state_in = W_DIV;
            end
         end
         default: state_in = W_IDLE;
      endcase
      if ((state_ff == W_IDLE && start) ||
          (state_ff == W_ACC && k_ff != TW'(WAVE_TERMS))) begin
         k_in    = k_next;
         num_in  = {kx_next, 16'd0};
         rem_in  = '0;
         quo_in  = '0;
         step_in = SW'(NUMW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff    <= k_in;
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      qpos_ff <= qpos_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign busy = state_ff != W_IDLE;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rwh_ripple_term.sv -----
`default_nettype none

module rwh_ripple_term import rwh_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire slot_beat_type       beat,
   input  wire logic [POS_W-1:0]    query_pos,
   output logic                     busy,
   output logic signed [ACC_W-1:0]  acc
);

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [POS_W-1:0]    d1_ff, d1_in;
   logic                neg1_ff, neg1_in;
   logic [14:0]         e1_ff, e1_in;
   logic [15:0]         tf1_ff, tf1_in, tf2_ff, tf3_ff;
   logic [STR_W-1:0]    str1_ff, str2_ff, str3_ff;
   logic [15:0]         ang2_ff, ang2_in;
   logic [13:0]         u2_ff, u2_in;
   logic [14:0]         fade3_ff, fade3_in, mag3_ff, mag3_in;
   logic                sign3_ff, sign3_in, sign4_ff, sign5_ff;
   logic [23:0]         p1_ff, p1_in;
   logic [30:0]         p2_ff, p2_in;
   logic [28:0]         m5_ff, m5_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic [21:0]         spread_full;
   logic signed [16:0]  s_val;
   logic [16:0]         tf_full;
   logic [30:0]         a_full;
   logic [18:0]         n_val;
   logic [38:0]         u_full;
   logic [29:0]         fade_full;
   logic signed [15:0]  sn;
   logic [54:0]         prod_full;

   always_comb begin
      d1_in       = (beat.position > query_pos) ? beat.position - query_pos
                                                 : query_pos - beat.position;
      spread_full = 22'(beat.age) * 22'd100;
      s_val       = $signed({2'b0, d1_in, 4'b0}) - $signed({7'b0, spread_full[21:12]});
      neg1_in     = s_val < 0;
      e1_in       = neg1_in ? 15'(-s_val) : 15'(s_val);
      tf_full     = 17'd65536 - 17'(beat.age) * 17'd3;
      tf1_in      = tf_full[16:1];

      a_full      = 31'(e1_ff) * 31'd33379;
      ang2_in     = neg1_ff ? 16'd0 - a_full[23:8] : a_full[23:8];
      n_val       = 19'(d1_ff) * 19'd8 + 19'(e1_ff) * 19'd10;
      u_full      = 39'(n_val) * 39'd671089;
      u2_in       = u_full[37:24];

      fade_full   = 30'(EXP_WHOLE[u2_ff[8:5]]) * 30'(EXP_PART[u2_ff[4:0]]) + 30'd16384;
      fade3_in    = (u2_ff >= 14'd352) ? 15'd0 : fade_full[29:15];
      sn          = sine_q15(ang2_ff);
      sign3_in    = sn < 0;
      mag3_in     = sign3_in ? 15'(-sn) : 15'(sn);

      p1_in       = 24'(mag3_ff) * 24'(str3_ff);
      p2_in       = 31'(tf3_ff) * 31'(fade3_ff);

      prod_full   = 55'(p1_ff) * 55'(p2_ff);
      m5_in       = prod_full[54:26];

      acc_in      = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (v5_ff) begin
         acc_in = sign5_ff ? acc_ff - ACC_W'(m5_ff) : acc_ff + ACC_W'(m5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= beat.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      d1_ff    <= d1_in;
      neg1_ff  <= neg1_in;
      e1_ff    <= e1_in;
      tf1_ff   <= tf1_in;
      str1_ff  <= beat.strength;
      ang2_ff  <= ang2_in;
      u2_ff    <= u2_in;
      tf2_ff   <= tf1_ff;
      str2_ff  <= str1_ff;
      fade3_ff <= fade3_in;
      mag3_ff  <= mag3_in;
      sign3_ff <= sign3_in;
      tf3_ff   <= tf2_ff;
      str3_ff  <= str2_ff;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      sign4_ff <= sign3_ff;
      m5_ff    <= m5_in;
      sign5_ff <= sign4_ff;
      acc_ff   <= acc_in;
   end

   assign busy = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
   assign acc  = acc_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ripple_water_height_engine_core.sv -----
`default_nettype none
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_command, req_position, req_strength,
//                      req_elapsed
// rsp       out        rsp_valid, rsp_ready, rsp_height
// csr       in         csr_valid, csr_ready, csr_index, csr_data
//
// Every tick, add or query walks the ripple table through its single read port, one
// slot a cycle; for a query the base wave unit runs beside the walk and takes each
// wave term through a divide, a multiply and an add. An add writes its slot in ST_ADD,
// entered from ST_DRAIN once the last slot read has returned. Unknown commands are taken
// and leave the core idle. Reset clears the slot valid bits and the phase at once.
// A finished height waits in the output register while the next beat is taken.

module ripple_water_height_engine_core import rwh_pkg::*; #(
   parameter int RIPPLE_SLOTS = SLOTS_DEFAULT,
   parameter int WAVE_TERMS   = TERMS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_W-1:0]      req_command,
   input  wire logic [POS_W-1:0]      req_position,
   input  wire logic [STR_W-1:0]      req_strength,
   input  wire logic [ELAPSED_W-1:0]  req_elapsed,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [HEIGHT_W-1:0]        rsp_height,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_data
);

   localparam int SLOT_W = (RIPPLE_SLOTS > 1) ? $clog2(RIPPLE_SLOTS) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   slot_word_type            mem [RIPPLE_SLOTS];
   slot_word_type            mem_q_ff;
   logic                     mem_re, mem_we;
   logic [SLOT_W-1:0]        mem_raddr, mem_waddr;
   slot_word_type            mem_wdata;

   logic [2:0]               state_ff, state_in;
   logic [SLOT_W-1:0]        cnt_ff, cnt_in;
   logic                     rd_valid_ff;
   logic [SLOT_W-1:0]        rd_idx_ff;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [STR_W-1:0]         str_ff, str_in;
   logic [ELAPSED_W-1:0]     el_ff, el_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [SWIDTH_W-1:0]      width_ff, width_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [RIPPLE_SLOTS-1:0]  active_ff, active_in;
   logic                     found_ff, found_in;
   logic [SLOT_W-1:0]        pick_ff, pick_in;
   logic                     best_v_ff, best_v_in;
   logic [AGE_W-1:0]         best_age_ff, best_age_in;
   logic [SLOT_W-1:0]        best_idx_ff, best_idx_in;
   logic signed [ACC_W-1:0]  total_ff, total_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [HEIGHT_W-1:0]      rsp_height_ff, rsp_height_in;

   logic                     accept, slot_live, wave_busy, term_busy;
   logic [PHASE_W+15:0]      phase_step;
   logic [16:0]              new_age;
   logic signed [ACC_W-1:0]  wave_acc, ripple_acc;
   logic [ACC_W-FRAC_W-1:0]  whole;
   slot_beat_type            beat;

   assign accept     = req_valid & req_ready;
   assign req_ready  = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign slot_live  = active_ff[rd_idx_ff];
   assign new_age    = 17'(mem_q_ff.age) + 17'(el_ff);
   assign phase_step = (PHASE_W+16)'(req_elapsed) * (PHASE_W+16)'(10430)
                       + (PHASE_W+16)'(32768);
   assign whole      = total_ff[ACC_W-1:FRAC_W];

   assign beat.valid    = rd_valid_ff & slot_live & (cmd_ff == CMD_QUERY);
   assign beat.position = mem_q_ff.position;
   assign beat.age      = mem_q_ff.age;
   assign beat.strength = mem_q_ff.strength;

   rwh_wave_unit #(
      .WAVE_TERMS(WAVE_TERMS)
   ) u_wave (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && req_command == CMD_QUERY),
      .query_pos    (req_position),
      .span_px      (width_ff),
      .phase        (phase_ff),
      .busy         (wave_busy),
      .acc          (wave_acc)
   );

   rwh_ripple_term u_term (
      .clock     (clock),
      .reset     (reset),
      .clear     (accept),
      .beat      (beat),
      .query_pos (pos_ff),
      .busy      (term_busy),
      .acc       (ripple_acc)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      str_in        = str_ff;
      el_in         = el_ff;
      phase_in      = phase_ff;
      width_in      = width_ff;
      level_in      = level_ff;
      active_in     = active_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_v_in     = best_v_ff;
      best_age_in   = best_age_ff;
      best_idx_in   = best_idx_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_height_in = rsp_height_ff;
      mem_re        = 1'b0;
      mem_raddr     = cnt_ff;
      mem_we        = 1'b0;
      mem_waddr     = rd_idx_ff;
      mem_wdata     = mem_q_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SPAN_PX:    width_in = csr_data[SWIDTH_W-1:0];
            CSR_BASE_LEVEL: level_in = csr_data[LEVEL_W-1:0];
            default:        ;
         endcase
      end

      if (rd_valid_ff && slot_live) begin
         if (cmd_ff == CMD_TICK) begin
            if (new_age >= LIFE_UNITS) begin
               active_in[rd_idx_ff] = 1'b0;
            end else begin
               mem_we        = 1'b1;
               mem_wdata.age = new_age[AGE_W-1:0];
            end
         end else if (cmd_ff == CMD_ADD && (!best_v_ff || mem_q_ff.age > best_age_ff)) begin
            best_v_in   = 1'b1;
            best_age_in = mem_q_ff.age;
            best_idx_in = rd_idx_ff;
         end
      end else if (rd_valid_ff && cmd_ff == CMD_ADD && !found_ff) begin
         found_in = 1'b1;
         pick_in  = rd_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_command;
               pos_in    = req_position;
               str_in    = req_strength;
               el_in     = req_elapsed;
               cnt_in    = '0;
               found_in  = 1'b0;
               best_v_in = 1'b0;
               if (req_command == CMD_TICK) begin
                  phase_in = phase_ff + phase_step[PHASE_W+15:16];
               end
               if (req_command == CMD_TICK || req_command == CMD_ADD ||
                   req_command == CMD_QUERY) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_re = 1'b1;
            cnt_in = cnt_ff + SLOT_W'(1);
            if (cnt_ff == SLOT_W'(RIPPLE_SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !term_busy && !wave_busy) begin
               if (cmd_ff == CMD_ADD) begin
                  state_in = ST_ADD;
               end else if (cmd_ff == CMD_QUERY) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ADD: begin
            mem_we             = 1'b1;
            mem_waddr          = found_ff ? pick_ff : best_idx_ff;
            mem_wdata.position = pos_ff;
            mem_wdata.age      = '0;
            mem_wdata.strength = str_ff;
            active_in[mem_waddr] = 1'b1;
            state_in           = ST_IDLE;
         end
         ST_SUM: begin
            total_in = ripple_acc + wave_acc + $signed({(ACC_W-LEVEL_W-FRAC_W)'(0),
                                                         level_ff, FRAC_W'(0)});
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (total_ff < 0) begin
                  rsp_height_in = '0;
               end else if (whole > (ACC_W-FRAC_W)'(4095)) begin
                  rsp_height_in = '1;
               end else begin
                  rsp_height_in = whole[HEIGHT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         phase_ff     <= '0;
         width_ff     <= SPAN_PX_RESET;
         level_ff     <= BASE_LEVEL_RESET;
         active_ff    <= '0;
         found_ff     <= 1'b0;
         best_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= mem_re;
         phase_ff     <= phase_in;
         width_ff     <= width_in;
         level_ff     <= level_in;
         active_ff    <= active_in;
         found_ff     <= found_in;
         best_v_ff    <= best_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= mem_raddr;
      cnt_ff        <= cnt_in;
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      str_ff        <= str_in;
      el_ff         <= el_in;
      pick_ff       <= pick_in;
      best_age_ff   <= best_age_in;
      best_idx_ff   <= best_idx_in;
      total_ff      <= total_in;
      rsp_height_ff <= rsp_height_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = rsp_height_ff;

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rd_valid_ff)
      else $error("slot read pending while idle");

   a_rmw_no_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("write and read of the same slot in one cycle");

   a_ready_units_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !term_busy && !wave_busy)
      else $error("beat taken while a query unit is still busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside the output state");

endmodule

`default_nettype wire

// ----- tb/ripple_water_height_engine_core_check.sv -----
`timescale 1ns / 100ps

module ripple_water_height_engine_core_check import rwh_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [CMD_W-1:0]     req_command,
   input  wire logic [POS_W-1:0]     req_position,
   input  wire logic [STR_W-1:0]     req_strength,
   input  wire logic [ELAPSED_W-1:0] req_elapsed,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [HEIGHT_W-1:0]  rsp_height,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output int                        fail_count,
   output int                        heights_pending
);

   localparam int SLOTS = SLOTS_DEFAULT;

   logic                slot_live [SLOTS];
   logic [POS_W-1:0]    slot_pos  [SLOTS];
   int unsigned         slot_age  [SLOTS];
   logic [STR_W-1:0]    slot_str  [SLOTS];
   logic [PHASE_W-1:0]  phase_acc;
   logic [SWIDTH_W-1:0] width_reg;
   logic [LEVEL_W-1:0]  level_reg;
   logic [HEIGHT_W-1:0] height_due [$];

   function automatic int table_sine(int unsigned angle);
      int unsigned idx;
      int unsigned k;
      idx = (((angle & 32'hFFFF) + 128) >> 8) & 255;
      k   = idx & 63;
      case (idx >> 6)
         0: return int'(SIN_QUARTER[k]);
         1: return int'(SIN_QUARTER[64 - k]);
         2: return -int'(SIN_QUARTER[k]);
         default: return -int'(SIN_QUARTER[64 - k]);
      endcase
   endfunction

   function automatic longint ripple_contrib(int slot, int unsigned x);
      int unsigned rp, ag, d, e, a, ang, u, fade, tf;
      int s, sn;
      longint unsigned mag;
      rp  = slot_pos[slot];
      ag  = slot_age[slot] & 32'h7FFF;
      d   = rp > x ? rp - x : x - rp;
      s   = int'(d * 16) - int'((ag * 100) >> 12);
      e   = s < 0 ? -s : s;
      a   = (e * 33379) >> 8;
      ang = s < 0 ? 0 - a : a;
      u   = (8 * d + 10 * e) / 25;
      if (u >= 352 || 3 * ag >= 65536) begin
         return 0;
      end
      fade = (int'(EXP_WHOLE[u >> 5]) * int'(EXP_PART[u & 31]) + 16384) >> 15;
      tf   = (65536 - 3 * ag) >> 1;
      sn   = table_sine(ang);
      mag  = longint'(sn < 0 ? -sn : sn) * longint'(slot_str[slot]) * longint'(tf)
             * longint'(fade);
      mag  = mag >> 26;
      return sn < 0 ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [HEIGHT_W-1:0] surface_height(int unsigned x);
      longint unsigned w, off;
      longint acc;
      int unsigned ang;
      w   = width_reg == 0 ? 1 : width_reg;
      acc = longint'(level_reg) * 8388608;
      for (int i = 0; i < TERMS_DEFAULT; i++) begin
         off = (longint'(i + 1) * x * 65536) / w;
         ang = int'((off + phase_acc) & 64'hFFFF);
         acc += longint'(table_sine(ang)) * longint'(WAVE_AMP[i]);
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i]) begin
            acc += ripple_contrib(i, x);
         end
      end
      if (acc < 0) begin
         return 0;
      end
      acc = acc / 8388608;
      return acc > 4095 ? 12'd4095 : acc[11:0];
   endfunction

   task automatic advance_time(int unsigned el);
      int unsigned na;
      phase_acc = phase_acc + 16'((el * 10430 + 32768) >> 16);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i]) begin
            na = slot_age[i] + el;
            if (na >= LIFE_UNITS) begin
               slot_live[i] = 1'b0;
            end else begin
               slot_age[i] = na;
            end
         end
      end
   endtask

   task automatic place_ripple(logic [POS_W-1:0] x, logic [STR_W-1:0] str);
      int pick;
      bit found;
      pick  = 0;
      found = 0;
      for (int i = 0; i < SLOTS && !found; i++) begin
         if (!slot_live[i]) begin
            pick  = i;
            found = 1;
         end
      end
      if (!found) begin
         for (int i = 1; i < SLOTS; i++) begin
            if (slot_age[i] > slot_age[pick]) begin
               pick = i;
            end
         end
      end
      slot_live[pick] = 1'b1;
      slot_pos[pick]  = x;
      slot_age[pick]  = 0;
      slot_str[pick]  = str;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_pos[i]  = '0;
            slot_age[i]  = 0;
            slot_str[i]  = '0;
         end
         phase_acc = '0;
         width_reg = SPAN_PX_RESET;
         level_reg = BASE_LEVEL_RESET;
         height_due.delete();
         fail_count      <= 0;
         heights_pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SPAN_PX) begin
               width_reg = csr_data[SWIDTH_W-1:0];
            end else if (csr_index == CSR_BASE_LEVEL) begin
               level_reg = csr_data[LEVEL_W-1:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (height_due.size() == 0) begin
               $display("%0t: unexpected height beat, expected none, actual %0d",
                        $time, rsp_height);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_height !== height_due[0]) begin
                  $display("%0t: height mismatch, expected %0d, actual %0d",
                           $time, height_due[0], rsp_height);
                  fail_count <= fail_count + 1;
               end
               void'(height_due.pop_front());
            end
         end
         if (req_valid && req_ready) begin
            case (req_command)
               CMD_TICK:  advance_time(req_elapsed);
               CMD_ADD:   place_ripple(req_position, req_strength);
               CMD_QUERY: height_due.push_back(surface_height(req_position));
               default: ;
            endcase
         end
         heights_pending <= height_due.size();
      end
   end

endmodule

// ----- tb/ripple_water_height_engine_core_test.sv -----
`timescale 1ns / 100ps

module ripple_water_height_engine_core_test import rwh_pkg::*;;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 600;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CMD_W-1:0]     req_command;
   logic [POS_W-1:0]     req_position;
   logic [STR_W-1:0]     req_strength;
   logic [ELAPSED_W-1:0] req_elapsed;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [HEIGHT_W-1:0]  rsp_height;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;
   int                   fail_count;
   int                   heights_pending;
   int                   req_idle_pct;
   int                   rsp_idle_pct;
   int                   quiet_cycles;

   ripple_water_height_engine_core i_dut (.*);

   ripple_water_height_engine_core_check i_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[ripple_water_height_engine_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                           logic [STR_W-1:0] str, logic [ELAPSED_W-1:0] el);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      req_strength <= str;
      req_elapsed  <= el;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (heights_pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_screen(logic [CSR_DAT_W-1:0] width, logic [CSR_DAT_W-1:0] level);
      drain_results();
      write_reg(CSR_SPAN_PX, width);
      write_reg(CSR_BASE_LEVEL, level);
   endtask

   // Short ticks keep ripples alive so queries see many overlapping terms.
   task automatic random_cmd();
      int pick;
      logic [ELAPSED_W-1:0] el;
      pick = $urandom_range(99);
      el   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(400));
      if (pick < 40) begin
         send_cmd(CMD_ADD, 11'($urandom), 9'($urandom), 16'($urandom));
      end else if (pick < 65) begin
         send_cmd(CMD_TICK, 11'($urandom), 9'($urandom), el);
      end else if (pick < 95) begin
         send_cmd(CMD_QUERY, 11'($urandom), 9'($urandom), 16'($urandom));
      end else begin
         send_cmd(2'd3, 11'($urandom), 9'($urandom), 16'($urandom));
      end
   endtask

   task automatic random_run(int count);
      for (int i = 0; i < count; i++) begin
         random_cmd();
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_command  = CMD_TICK;
      req_position = '0;
      req_strength = '0;
      req_elapsed  = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_SPAN_PX;
      csr_data     = '0;
      req_idle_pct = 36;
      rsp_idle_pct = 78;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cmd(CMD_QUERY, 11'd0, 9'd0, 16'd0);
      send_cmd(CMD_QUERY, 11'd2047, 9'd511, 16'hFFFF);
      send_cmd(CMD_ADD, 11'd0, 9'd0, 16'd0);
      send_cmd(CMD_ADD, 11'd2047, 9'd511, 16'd0);
      send_cmd(CMD_ADD, 11'd1000, 9'd128, 16'd0);
      send_cmd(CMD_ADD, 11'd1010, 9'd256, 16'd0);
      send_cmd(CMD_QUERY, 11'd1000, 9'd0, 16'd0);
      send_cmd(CMD_QUERY, 11'd0, 9'd0, 16'd0);
      send_cmd(CMD_TICK, 11'd0, 9'd0, 16'd0);
      send_cmd(CMD_TICK, 11'd0, 9'd0, 16'd1);
      send_cmd(CMD_QUERY, 11'd1005, 9'd0, 16'd0);
      send_cmd(CMD_TICK, 11'd0, 9'd0, 16'd21844);
      send_cmd(CMD_QUERY, 11'd1001, 9'd0, 16'd0);
      send_cmd(CMD_TICK, 11'd0, 9'd0, 16'd1);
      send_cmd(CMD_QUERY, 11'd1001, 9'd0, 16'd0);
      send_cmd(2'd3, 11'd2047, 9'd511, 16'hFFFF);
      send_cmd(CMD_ADD, 11'd500, 9'd256, 16'd0);
      send_cmd(CMD_TICK, 11'd0, 9'd0, 16'hFFFF);
      send_cmd(CMD_QUERY, 11'd500, 9'd0, 16'd0);
      send_cmd(CMD_ADD, 11'd0, 9'd511, 16'd0);
      send_cmd(CMD_QUERY, 11'd0, 9'd0, 16'd0);

      set_screen(12'd0, 12'd0);
      random_run(120);
      set_screen(12'd2047, 12'd4095);
      random_run(120);

      req_idle_pct = 78;
      rsp_idle_pct = 36;
      set_screen(12'd1, 12'($urandom));
      random_run(120);
      set_screen(12'hFFF, 12'($urandom_range(300, 600)));
      random_run(120);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_screen(12'd1024, 12'd360);
      random_run(60);
      set_screen(12'($urandom), 12'($urandom_range(200, 3900)));
      // Clear the table, then fill it so later adds replace the oldest ripple.
      send_cmd(CMD_TICK, 11'd0, 9'd0, 16'hFFFF);
      for (int i = 0; i < 262; i++) begin
         send_cmd(CMD_ADD, 11'($urandom), 9'($urandom_range(128, 256)), 16'd0);
         if (i % 64 == 63) begin
            send_cmd(CMD_TICK, 11'd0, 9'd0, 16'($urandom_range(50)));
            send_cmd(CMD_QUERY, 11'($urandom), 9'd0, 16'd0);
         end
      end
      random_run(70);

      drain_results();
      if (fail_count == 0) begin
         $display("[ripple_water_height_engine_core] OK");
      end else begin
         $display("[ripple_water_height_engine_core] ERROR");
      end
      $finish;
   end

endmodule
